/* hw/rtl/planar_dead_reckoning_core_assert.svh */
// Assertion helpers for the dead-reckoning core.
`ifndef PLANAR_DEAD_RECKONING_CORE_ASSERT_SVH
`define PLANAR_DEAD_RECKONING_CORE_ASSERT_SVH

// Same-cycle implication, disabled while reset is low.
`define PDR_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is low.
`define PDR_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* hw/rtl/pdr_pkg.sv */
`default_nettype none

package pdr_pkg;

    localparam int CORDIC_STEPS = 16;
    localparam int CORDIC_ITERS = (CORDIC_STEPS < 32) ? CORDIC_STEPS : 32;
    localparam int ITER_W       = 5;
    localparam logic [ITER_W-1:0] ITER_LAST = ITER_W'(CORDIC_ITERS - 1);

    // Rotator lanes are Q4.26 plus headroom for quarter turns and gain.
    localparam int CORD_W  = 34;
    localparam int MUL_A_W = CORD_W;
    localparam int MUL_B_W = 32;
    localparam int PROD_W  = MUL_A_W + MUL_B_W;

    localparam logic signed [MUL_B_W-1:0] GAIN_Q30       = 32'sd652032874;
    localparam logic signed [MUL_B_W-1:0] RAD_TO_BAM_Q29 = 32'sd1367130551;

    // Arctangent of 2^-i as a binary angle.
    function automatic logic [31:0] atan_bam(input logic [ITER_W-1:0] idx);
        logic [31:0] v;
        case (idx)
            5'd0:    v = 32'd536870912;
            5'd1:    v = 32'd316933406;
            5'd2:    v = 32'd167458907;
            5'd3:    v = 32'd85004756;
            5'd4:    v = 32'd42667331;
            5'd5:    v = 32'd21354465;
            5'd6:    v = 32'd10679838;
            5'd7:    v = 32'd5340245;
            5'd8:    v = 32'd2670163;
            5'd9:    v = 32'd1335087;
            5'd10:   v = 32'd667544;
            5'd11:   v = 32'd333772;
            5'd12:   v = 32'd166886;
            5'd13:   v = 32'd83443;
            5'd14:   v = 32'd41722;
            5'd15:   v = 32'd20861;
            5'd16:   v = 32'd10430;
            5'd17:   v = 32'd5215;
            5'd18:   v = 32'd2608;
            5'd19:   v = 32'd1304;
            5'd20:   v = 32'd652;
            5'd21:   v = 32'd326;
            5'd22:   v = 32'd163;
            5'd23:   v = 32'd81;
            5'd24:   v = 32'd41;
            5'd25:   v = 32'd20;
            5'd26:   v = 32'd10;
            5'd27:   v = 32'd5;
            5'd28:   v = 32'd3;
            5'd29:   v = 32'd1;
            5'd30:   v = 32'd1;
            default: v = 32'd0;
        endcase
        return v;
    endfunction

endpackage

`default_nettype wire

/* hw/rtl/pdr_mul.sv */
`default_nettype none

// Shared signed multiplier with a registered product.
module pdr_mul (
    input  wire logic                                 i_clk,
    input  wire logic                                 i_en,
    input  wire logic signed [pdr_pkg::MUL_A_W-1:0]   i_a,
    input  wire logic signed [pdr_pkg::MUL_B_W-1:0]   i_b,
    output logic signed      [pdr_pkg::PROD_W-1:0]    o_prod
);

    logic signed [pdr_pkg::PROD_W-1:0] r_prod;
    logic signed [pdr_pkg::PROD_W-1:0] n_prod;

    assign n_prod = pdr_pkg::PROD_W'(i_a) * pdr_pkg::PROD_W'(i_b);

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_prod <= n_prod;
        end
    end

    assign o_prod = r_prod;

endmodule

`default_nettype wire

/* hw/rtl/planar_dead_reckoning_core.sv */
`default_nettype none

// Planar dead-reckoning core. Each accepted item is one odometry tick: body
// velocities (forward, sideways, Q4.12 m/s), yaw rate (Q4.12 rad/s) and the
// elapsed time (2^-16 s). The core turns the velocity by the stored heading
// (exact quarter turn, then a CORDIC rotator of CORDIC_ITERS steps), corrects
// the CORDIC gain, scales by the elapsed time and adds into x and y (Q16.16 m,
// wrapping). Only then is yaw rate times time added to the heading, a 32-bit
// binary angle where 2^32 is a full turn. One result item, the updated pose,
// follows every tick. After accept the core makes the quarter turn, runs the
// one-step-per-cycle CORDIC loop, then makes six passes through the single
// shared multiplier (two gain corrections, two time scalings, two for the
// heading step), steps the heading and publishes; only then, back in idle,
// is the next tick taken. The result sits in its own output register, so a
// new tick is accepted while the previous pose waits to be taken; the core
// only stalls, before publishing, while that register is still full.
module planar_dead_reckoning_core (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_in_valid,
    output logic                    o_in_ready,
    input  wire logic signed [15:0] i_vel_forward,
    input  wire logic signed [15:0] i_vel_side,
    input  wire logic signed [15:0] i_yaw_rate,
    input  wire logic        [15:0] i_elapsed_time,
    output logic                    o_out_valid,
    input  wire logic               i_out_ready,
    output logic signed [31:0]      o_pose_x,
    output logic signed [31:0]      o_pose_y,
    output logic        [31:0]      o_pose_heading
);

    localparam int CW = pdr_pkg::CORD_W;
    localparam int PW = pdr_pkg::PROD_W;

    // Rounding offsets: half of the last kept unit.
    localparam logic signed [PW-1:0] HALF26 = PW'(1) <<< 25;
    localparam logic signed [PW-1:0] HALF29 = PW'(1) <<< 28;
    localparam logic signed [PW-1:0] HALF30 = PW'(1) <<< 29;

    typedef enum logic [3:0] {
        ST_IDLE,  // wait for a tick
        ST_ROT,   // quarter turn, load residual angle
        ST_ITER,  // CORDIC micro-rotations
        ST_GX,    // x times gain
        ST_GY,    // round x, y times gain
        ST_DX,    // round y, x times dt
        ST_DY,    // step x, y times dt
        ST_W1,    // step y, yaw rate times dt
        ST_W2,    // times rad-to-angle scale
        ST_HD,    // step heading
        ST_DONE   // publish pose once the output register is free
    } t_state;

    t_state r_state, n_state;
    logic [pdr_pkg::ITER_W-1:0] r_iter, n_iter;

    // Latched tick.
    logic signed [15:0] r_vf, n_vf;
    logic signed [15:0] r_vs, n_vs;
    logic signed [15:0] r_wz, n_wz;
    logic        [15:0] r_dt, n_dt;

    // Rotator lanes and residual angle.
    logic signed [CW-1:0] r_cx, n_cx;
    logic signed [CW-1:0] r_cy, n_cy;
    logic signed [31:0]   r_z,  n_z;

    // Pose state.
    logic [31:0] r_pos_x, n_pos_x;
    logic [31:0] r_pos_y, n_pos_y;
    logic [31:0] r_head,  n_head;

    // Output register.
    logic        r_out_valid, n_out_valid;
    logic [31:0] r_out_x, n_out_x;
    logic [31:0] r_out_y, n_out_y;
    logic [31:0] r_out_h, n_out_h;

    // Shared multiplier.
    logic                               mul_en;
    logic signed [pdr_pkg::MUL_A_W-1:0] mul_a;
    logic signed [pdr_pkg::MUL_B_W-1:0] mul_b;
    logic signed [PW-1:0]               w_prod;

    pdr_mul u_mul (
        .i_clk  (i_clk),
        .i_en   (mul_en),
        .i_a    (mul_a),
        .i_b    (mul_b),
        .o_prod (w_prod)
    );

    // Quarter-turn split of the heading.
    logic [1:0]           w_q;
    logic [31:0]          w_res;
    logic signed [CW-1:0] w_x0, w_y0;
    // CORDIC step.
    logic signed [CW-1:0] w_sx, w_sy;
    logic signed [31:0]   w_atan;
    // Rounded products.
    logic signed [PW-1:0] w_rnd26, w_rnd29, w_rnd30;

    assign w_q   = r_head[31:30] + {1'b0, r_head[29]};
    assign w_res = r_head - {w_q, 30'b0};
    assign w_x0  = CW'(r_vf) <<< 14;
    assign w_y0  = CW'(r_vs) <<< 14;

    assign w_sx   = r_cx >>> r_iter;
    assign w_sy   = r_cy >>> r_iter;
    assign w_atan = signed'(pdr_pkg::atan_bam(r_iter));

    assign w_rnd26 = (w_prod + HALF26) >>> 26;
    assign w_rnd29 = (w_prod + HALF29) >>> 29;
    assign w_rnd30 = (w_prod + HALF30) >>> 30;

    assign o_in_ready = (r_state == ST_IDLE);

    always_comb begin
        n_state     = r_state;
        n_iter      = r_iter;
        n_vf        = r_vf;
        n_vs        = r_vs;
        n_wz        = r_wz;
        n_dt        = r_dt;
        n_cx        = r_cx;
        n_cy        = r_cy;
        n_z         = r_z;
        n_pos_x     = r_pos_x;
        n_pos_y     = r_pos_y;
        n_head      = r_head;
        n_out_valid = r_out_valid && !i_out_ready;
        n_out_x     = r_out_x;
        n_out_y     = r_out_y;
        n_out_h     = r_out_h;
        mul_en      = 1'b0;
        mul_a       = r_cx;
        mul_b       = pdr_pkg::GAIN_Q30;

        case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    n_vf    = i_vel_forward;
                    n_vs    = i_vel_side;
                    n_wz    = i_yaw_rate;
                    n_dt    = i_elapsed_time;
                    n_state = ST_ROT;
                end
            end
            ST_ROT: begin
                // Turn exactly by the quarter turns, keep the residual for CORDIC.
                case (w_q)
                    2'd0: begin
                        n_cx = w_x0;
                        n_cy = w_y0;
                    end
                    2'd1: begin
                        n_cx = -w_y0;
                        n_cy = w_x0;
                    end
                    2'd2: begin
                        n_cx = -w_x0;
                        n_cy = -w_y0;
                    end
                    default: begin
                        n_cx = w_y0;
                        n_cy = -w_x0;
                    end
                endcase
                n_z     = signed'(w_res);
                n_iter  = '0;
                n_state = ST_ITER;
            end
            ST_ITER: begin
                if (!r_z[31]) begin
                    n_cx = r_cx - w_sy;
                    n_cy = r_cy + w_sx;
                    n_z  = r_z - w_atan;
                end else begin
                    n_cx = r_cx + w_sy;
                    n_cy = r_cy - w_sx;
                    n_z  = r_z + w_atan;
                end
                if (r_iter == pdr_pkg::ITER_LAST) begin
                    n_iter  = '0;
                    n_state = ST_GX;
                end else begin
                    n_iter = r_iter + 1'b1;
                end
            end
            ST_GX: begin
                mul_en  = 1'b1;
                mul_a   = r_cx;
                mul_b   = pdr_pkg::GAIN_Q30;
                n_state = ST_GY;
            end
            ST_GY: begin
                n_cx    = w_rnd30[CW-1:0];
                mul_en  = 1'b1;
                mul_a   = r_cy;
                mul_b   = pdr_pkg::GAIN_Q30;
                n_state = ST_DX;
            end
            ST_DX: begin
                n_cy    = w_rnd30[CW-1:0];
                mul_en  = 1'b1;
                mul_a   = r_cx;
                mul_b   = {16'h0000, r_dt};
                n_state = ST_DY;
            end
            ST_DY: begin
                n_pos_x = r_pos_x + w_rnd26[31:0];
                mul_en  = 1'b1;
                mul_a   = r_cy;
                mul_b   = {16'h0000, r_dt};
                n_state = ST_W1;
            end
            ST_W1: begin
                n_pos_y = r_pos_y + w_rnd26[31:0];
                mul_en  = 1'b1;
                mul_a   = CW'(r_wz);
                mul_b   = {16'h0000, r_dt};
                n_state = ST_W2;
            end
            ST_W2: begin
                // Yaw rate times dt fits in 32 signed bits.
                mul_en  = 1'b1;
                mul_a   = w_prod[CW-1:0];
                mul_b   = pdr_pkg::RAD_TO_BAM_Q29;
                n_state = ST_HD;
            end
            ST_HD: begin
                n_head  = r_head + w_rnd29[31:0];
                n_state = ST_DONE;
            end
            ST_DONE: begin
                // Hold the pose until the output register frees up.
                if (!r_out_valid || i_out_ready) begin
                    n_out_valid = 1'b1;
                    n_out_x     = r_pos_x;
                    n_out_y     = r_pos_y;
                    n_out_h     = r_head;
                    n_state     = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_iter      <= '0;
            r_pos_x     <= '0;
            r_pos_y     <= '0;
            r_head      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_iter      <= n_iter;
            r_pos_x     <= n_pos_x;
            r_pos_y     <= n_pos_y;
            r_head      <= n_head;
            r_out_valid <= n_out_valid;
        end
        r_vf    <= n_vf;
        r_vs    <= n_vs;
        r_wz    <= n_wz;
        r_dt    <= n_dt;
        r_cx    <= n_cx;
        r_cy    <= n_cy;
        r_z     <= n_z;
        r_out_x <= n_out_x;
        r_out_y <= n_out_y;
        r_out_h <= n_out_h;
    end

    assign o_out_valid    = r_out_valid;
    assign o_pose_x       = r_out_x;
    assign o_pose_y       = r_out_y;
    assign o_pose_heading = r_out_h;

`include "planar_dead_reckoning_core_assert.svh"

`PDR_ASSERT_NEXT(a_busy_after_accept, i_clk, i_rst_n, i_in_valid && o_in_ready, !o_in_ready, "core took a second item while busy")
`PDR_ASSERT_NOW(a_iter_idle, i_clk, i_rst_n, r_state != ST_ITER, r_iter == '0, "iteration count left over outside the rotator loop")
`PDR_ASSERT_NEXT(a_head_only_in_hd, i_clk, i_rst_n, r_state != ST_HD, $stable(r_head), "heading moved outside its update step")
`PDR_ASSERT_NEXT(a_zero_dt_x, i_clk, i_rst_n, r_state == ST_DY && r_dt == 16'h0000, $stable(r_pos_x), "x moved on a tick with zero elapsed time")

endmodule

`default_nettype wire
